// File: src/seven_segment_number_formatter_macros.svh
// Assertion helpers used by the checker of the number formatter.
`ifndef SEVEN_SEGMENT_NUMBER_FORMATTER_MACROS_SVH
`define SEVEN_SEGMENT_NUMBER_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSNF_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("seven segment formatter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSNF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("seven segment formatter: next-cycle check failed");

`endif

// File: src/ssnf_pkg.sv
package ssnf_pkg;

  localparam int unsigned ValueW    = 51;
  localparam int unsigned BinW      = ValueW - 1;
  localparam int unsigned NumDigits = 16;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned Steps     = 5;
  localparam int unsigned NumStages = BinW / Steps;
  localparam int unsigned NumOut    = 8;
  localparam int unsigned PosW      = $clog2(NumOut);

  localparam logic [7:0] DashSeg  = 8'h02;
  localparam logic [7:0] PointSeg = 8'h01;

  typedef struct packed {
    logic            cmd;
    logic            neg;
    logic            zero;
    logic [BinW-1:0] bin;
    logic [BcdW-1:0] bcd;
  } work_t;

  function automatic logic [7:0] seg_digit(logic [3:0] dg);
    logic [7:0] s;
    case (dg)
      4'd0:    s = 8'hfc;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hda;
      4'd3:    s = 8'hf2;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'hb6;
      4'd6:    s = 8'hbe;
      4'd7:    s = 8'he0;
      4'd8:    s = 8'hfe;
      4'd9:    s = 8'hf6;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // One shift-and-add-three step of the binary to BCD conversion.
  function automatic work_t dabble_step(work_t w);
    work_t      r;
    logic [3:0] dg;
    r = w;
    for (int d = 0; d < NumDigits; d++) begin
      dg = w.bcd[d*4 +: 4];
      if (dg >= 4'd5) begin
        r.bcd[d*4 +: 4] = dg + 4'd3;
      end
    end
    {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    return r;
  endfunction

endpackage

// File: src/ssnf_req_if.sv
interface ssnf_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic signed [ssnf_pkg::ValueW-1:0]   value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

// File: src/ssnf_rsp_if.sv
interface ssnf_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [ssnf_pkg::PosW-1:0]  digit_pos;
  logic [7:0]                 segments;
  logic                       last;

  modport source (output valid, output digit_pos, output segments, output last, input ready);
  modport sink (input valid, input digit_pos, input segments, input last, output ready);
endinterface

// File: src/ssnf_dabble_stage.sv
module ssnf_dabble_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  ssnf_pkg::work_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output ssnf_pkg::work_t data_o
);

  logic            valid_q;
  ssnf_pkg::work_t data_d, data_q;

  // Advance when the stage is empty or its contents move on.
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d = data_i;
    for (int s = 0; s < ssnf_pkg::Steps; s++) begin
      data_d = ssnf_pkg::dabble_step(data_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/ssnf_digit_ser.sv
module ssnf_digit_ser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  ssnf_pkg::work_t           data_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [ssnf_pkg::PosW-1:0] digit_pos_o,
  output logic [7:0]                segments_o,
  output logic                      last_o
);

  localparam int unsigned ShownDigits = ssnf_pkg::NumDigits - 1;
  localparam logic [3:0]  UnitsIdx    = 4'd7;
  localparam logic [ssnf_pkg::PosW-1:0] LastPos = ssnf_pkg::PosW'(ssnf_pkg::NumOut - 1);

  logic                             busy_d, busy_q;
  logic [ssnf_pkg::PosW-1:0]        cnt_d, cnt_q;
  logic                             dash_q, point_q;
  logic [3:0]                       top_q, top_d;
  logic [ShownDigits-1:0][3:0]      bcd_q;

  logic                             out_valid_d, out_valid_q;
  logic [ssnf_pkg::PosW-1:0]        pos_q;
  logic [7:0]                       seg_d, seg_q;
  logic                             last_q;

  logic                             adv, load, drop;
  logic [3:0]                       k;

  assign adv     = !out_valid_q || ready_i;
  assign ready_o = !busy_q || (adv && cnt_q == LastPos);
  assign load    = valid_i && ready_o;
  // Drop a decimal value of sixteen digits: nothing is shown for it.
  assign drop    = !data_i.neg && data_i.cmd && (data_i.bcd[ssnf_pkg::BcdW-1 -: 4] != 4'd0);

  always_comb begin
    top_d = UnitsIdx;
    if (data_i.cmd) begin
      for (int i = 8; i < ShownDigits; i++) begin
        if (data_i.bcd[i*4 +: 4] != 4'd0) begin
          top_d = 4'(i);
        end
      end
    end
  end

  assign k = top_q - {1'b0, cnt_q};

  always_comb begin
    if (dash_q) begin
      seg_d = ssnf_pkg::DashSeg;
    end else begin
      seg_d = ssnf_pkg::seg_digit(bcd_q[k]);
      if (point_q && k == UnitsIdx) begin
        seg_d = seg_d | ssnf_pkg::PointSeg;
      end
    end
  end

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastPos) begin
          busy_d = 1'b0;
        end
      end
    end
    if (load) begin
      busy_d = !drop;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dash_q  <= data_i.neg || (data_i.cmd && data_i.zero);
      point_q <= data_i.cmd;
      top_q   <= top_d;
      bcd_q   <= data_i.bcd[4*ShownDigits-1:0];
    end
    if (adv && busy_q) begin
      pos_q  <= cnt_q;
      seg_q  <= seg_d;
      last_q <= (cnt_q == LastPos);
    end
  end

  assign valid_o     = out_valid_q;
  assign digit_pos_o = pos_q;
  assign segments_o  = seg_q;
  assign last_o      = last_q;

endmodule

// File: src/seven_segment_number_formatter.sv
// Path: the ten conversion stages (five shift steps each), then the sequencer.
// Throughput: set by the eight-digit output; the sequencer takes a new request
//   as its last digit is issued; a stage takes a request every cycle it has room.
// Reset: asynchronous, active low; clears the valid bits of every stage and the
//   digit sequencer; payload registers are not reset.
module seven_segment_number_formatter (
  input  logic               clk_i,
  input  logic               rst_ni,
  ssnf_req_if.sink           req_i,
  ssnf_rsp_if.source         rsp_o
);

  localparam int unsigned NumStages = ssnf_pkg::NumStages;

  // Stage k's input sits at index k; index NumStages feeds the digit sequencer.
  logic            [NumStages:0] stg_valid;
  logic            [NumStages:0] stg_ready;
  ssnf_pkg::work_t               stg_data [NumStages+1];

  // Take the request apart: sign, zero flag and the bits below the sign, with an
  // empty BCD accumulator for the shift-and-add-three conversion.
  always_comb begin
    stg_data[0].cmd  = req_i.cmd;
    stg_data[0].neg  = req_i.value[ssnf_pkg::ValueW-1];
    stg_data[0].zero = (req_i.value[ssnf_pkg::BinW-1:0] == '0);
    stg_data[0].bin  = req_i.value[ssnf_pkg::BinW-1:0];
    stg_data[0].bcd  = '0;
  end

  assign stg_valid[0] = req_i.valid;
  assign req_i.ready  = stg_ready[0];

  // Conversion pipeline: each stage applies five steps and holds its result
  // until the next stage has room.
  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    ssnf_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .ready_o (stg_ready[g]),
      .data_i  (stg_data[g]),
      .valid_o (stg_valid[g+1]),
      .ready_i (stg_ready[g+1]),
      .data_o  (stg_data[g+1])
    );
  end

  // Digit sequencer: pick the format, then emit eight digits, leftmost first,
  // via its own output register, so a stalled last digit never blocks a load.
  ssnf_digit_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stg_valid[NumStages]),
    .ready_o     (stg_ready[NumStages]),
    .data_i      (stg_data[NumStages]),
    .valid_o     (rsp_o.valid),
    .ready_i     (rsp_o.ready),
    .digit_pos_o (rsp_o.digit_pos),
    .segments_o  (rsp_o.segments),
    .last_o      (rsp_o.last)
  );

endmodule

// File: src/ssnf_checker.sv
`include "seven_segment_number_formatter_macros.svh"

module ssnf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic [ssnf_pkg::PosW-1:0] rsp_digit_pos_i,
  input logic                      rsp_last_i
);

  localparam logic [ssnf_pkg::PosW-1:0] LastPos = ssnf_pkg::PosW'(ssnf_pkg::NumOut - 1);
  localparam logic [ssnf_pkg::PosW-1:0] OnePos  = ssnf_pkg::PosW'(1);

  `SSNF_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_digit_pos_i) && $stable(rsp_last_i))
  `SSNF_ASSERT_SAME(a_last_at_end, clk_i, rst_ni, rsp_valid_i, rsp_last_i == (rsp_digit_pos_i == LastPos))
  `SSNF_ASSERT_NEXT(a_pos_advance, clk_i, rst_ni, rsp_valid_i && rsp_ready_i && !rsp_last_i, rsp_valid_i && (rsp_digit_pos_i == $past(rsp_digit_pos_i) + OnePos))
  `SSNF_ASSERT_NEXT(a_pos_wrap, clk_i, rst_ni, rsp_valid_i && rsp_ready_i && rsp_last_i, !rsp_valid_i || (rsp_digit_pos_i == '0))

endmodule

bind seven_segment_number_formatter ssnf_checker u_ssnf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_digit_pos_i (rsp_o.digit_pos),
  .rsp_last_i      (rsp_o.last)
);
